>>> rtl/core/i2cmbe_pkg.sv
// shared types, opcodes and phase timings for the i2c master bit engine
package i2cmbe_pkg;

    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TICKS_W     = 10;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned BIT_CNT_W   = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [OPCODE_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SEND  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_WAIT  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_UNIT_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_POLL_LIMIT   = 1'd1;

    localparam logic [TICKS_W-1:0] DELAY_UNIT_TICKS_RST = 10'd1;
    localparam logic [TICKS_W-1:0] ACK_POLL_LIMIT_RST   = 10'd250;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

    // phase marks, counted in delay units; send and read restart at entry for each bit
    localparam logic [PHASE_W-1:0] PH_ENTRY      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_SDA  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_START_END  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP_RISE  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_END   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SEND_HIGH  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SEND_LOW   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SEND_NEXT  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_READ_HIGH  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_READ_NEXT  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_RACK_HIGH  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RACK_END   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WAIT_HIGH  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_POLL  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_STOP  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_RISE  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WAIT_END   = 4'd11;

    typedef struct packed {
        logic [OPCODE_W-1:0]  cur_op;
        logic [PHASE_W-1:0]   phase;
        logic [BIT_CNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]    shift_reg;
        logic [TICKS_W-1:0]   delay_count;
        logic [TICKS_W-1:0]   poll_count;
        logic                 scl;
        logic                 sda;
        logic                 sda_oe;
        logic                 ack_choice;
        logic [BYTE_W-1:0]    rx_hold;
    } t_state;

    typedef struct packed {
        logic done;
        logic fail;
    } t_flags;

endpackage

>>> rtl/core/i2cmbe_if.sv
// request, result and register write channels of the i2c master bit engine
interface i2cmbe_req_if;
    logic                          valid;
    logic                          ready;
    logic [i2cmbe_pkg::OPCODE_W-1:0] opcode;
    logic [i2cmbe_pkg::BYTE_W-1:0]   tx_byte;
    logic                          send_ack;
    logic                          sda_sample;

    modport source (output valid, opcode, tx_byte, send_ack, sda_sample, input ready);
    modport sink   (input valid, opcode, tx_byte, send_ack, sda_sample, output ready);
endinterface

interface i2cmbe_res_if;
    logic                        valid;
    logic                        ready;
    logic                        scl_level;
    logic                        sda_level;
    logic                        sda_drive_enable;
    logic                        ready_res;
    logic                        op_done;
    logic [i2cmbe_pkg::BYTE_W-1:0] rx_byte;
    logic                        ack_failed;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, ready_res,
                    op_done, rx_byte, ack_failed, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, ready_res,
                    op_done, rx_byte, ack_failed, output ready);
endinterface

interface i2cmbe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2cmbe_pkg::CFG_INDEX_W-1:0] index;
    logic [i2cmbe_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/i2c_master_bit_engine_core.sv
// i2c master bit engine: one request per timebase tick, one result per request
//
// i_req carries one tick of the delay timebase: an opcode (none, start, stop,
// send byte, read byte, wait ack), the byte to send, the ack choice for a read
// and the sampled SDA level. A command is taken only while the engine is idle;
// a command arriving while busy is ignored, but the tick itself still counts.
// o_res returns, for every request, the SCL and SDA drive, the SDA enable,
// the idle flag, command done, the last received byte and the ack failure.
// i_cfg writes delay_unit_ticks (index 0) and ack_poll_limit (index 1); it is
// always ready and is meant to be written while the engine is idle.
// Throughput is one request per cycle while results are taken: a single pass
// of logic feeds the state and result registers, and the result is valid in
// the cycle after its request is taken. When the receiver stalls, the result
// register holds and i_req.ready drops until it is taken; no tick is lost.
// Reset sets SCL, SDA and SDA enable high, the engine idle, delay unit 1 and
// poll limit 250, and empties the result register.
module i2c_master_bit_engine_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    i2cmbe_req_if.sink           i_req,
    i2cmbe_res_if.source         o_res,
    i2cmbe_cfg_if.sink           i_cfg
);

    i2cmbe_pkg::t_state                r_state;
    i2cmbe_pkg::t_state                n_state;
    i2cmbe_pkg::t_flags                step_flags;
    logic [i2cmbe_pkg::TICKS_W-1:0]    r_delay_ticks;
    logic [i2cmbe_pkg::TICKS_W-1:0]    r_poll_limit;
    logic                              r_out_valid;
    logic                              r_scl_level;
    logic                              r_sda_level;
    logic                              r_sda_oe;
    logic                              r_ready_res;
    logic                              r_op_done;
    logic [i2cmbe_pkg::BYTE_W-1:0]     r_rx_byte;
    logic                              r_ack_failed;
    logic                              req_take;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_take    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    i2cmbe_step u_step (
        .i_state       (r_state),
        .i_delay_ticks (r_delay_ticks),
        .i_poll_limit  (r_poll_limit),
        .i_opcode      (i_req.opcode),
        .i_tx_byte     (i_req.tx_byte),
        .i_send_ack    (i_req.send_ack),
        .i_sda_sample  (i_req.sda_sample),
        .o_state       (n_state),
        .o_flags       (step_flags)
    );

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{cur_op: i2cmbe_pkg::OP_NONE, phase: i2cmbe_pkg::PH_ENTRY,
                         bit_count: '0, shift_reg: '0, delay_count: '0,
                         poll_count: '0, scl: 1'b1, sda: 1'b1, sda_oe: 1'b1,
                         ack_choice: 1'b0, rx_hold: '0};
        end else if (req_take) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= i2cmbe_pkg::DELAY_UNIT_TICKS_RST;
            r_poll_limit  <= i2cmbe_pkg::ACK_POLL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                i2cmbe_pkg::REG_DELAY_UNIT_TICKS: r_delay_ticks <= i_cfg.data;
                i2cmbe_pkg::REG_ACK_POLL_LIMIT:   r_poll_limit  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_scl_level  <= n_state.scl;
            r_sda_level  <= n_state.sda;
            r_sda_oe     <= n_state.sda_oe;
            r_ready_res  <= (n_state.cur_op == i2cmbe_pkg::OP_NONE);
            r_op_done    <= step_flags.done;
            r_rx_byte    <= n_state.rx_hold;
            r_ack_failed <= step_flags.fail;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.scl_level        = r_scl_level;
    assign o_res.sda_level        = r_sda_level;
    assign o_res.sda_drive_enable = r_sda_oe;
    assign o_res.ready_res        = r_ready_res;
    assign o_res.op_done          = r_op_done;
    assign o_res.rx_byte          = r_rx_byte;
    assign o_res.ack_failed       = r_ack_failed;

`ifndef SYNTHESIS
    a_idle_flag_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.ready_res == (r_state.cur_op == i2cmbe_pkg::OP_NONE)))
        else $error("idle flag disagrees with engine state");

    a_fail_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ack_failed) |->
            (o_res.op_done && o_res.scl_level && o_res.sda_level && o_res.sda_drive_enable))
        else $error("ack failure without a completed stop condition");

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= i2cmbe_pkg::PH_WAIT_END)
        else $error("phase beyond the longest sequence");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_take |=> $stable(r_state))
        else $error("engine state moved without a request");
`endif

endmodule

>>> rtl/core/i2cmbe_step.sv
// next state of the bit engine for one timebase tick
module i2cmbe_step (
    input  i2cmbe_pkg::t_state                      i_state,
    input  logic [i2cmbe_pkg::TICKS_W-1:0]          i_delay_ticks,
    input  logic [i2cmbe_pkg::TICKS_W-1:0]          i_poll_limit,
    input  logic [i2cmbe_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]           i_tx_byte,
    input  logic                                    i_send_ack,
    input  logic                                    i_sda_sample,
    output i2cmbe_pkg::t_state                      o_state,
    output i2cmbe_pkg::t_flags                      o_flags
);

    i2cmbe_pkg::t_state                n;
    logic                              enter;
    logic                              done;
    logic                              fail;
    logic [i2cmbe_pkg::TICKS_W-1:0]    delay_inc;

    always_comb begin
        n         = i_state;
        enter     = 1'b0;
        done      = 1'b0;
        fail      = 1'b0;
        delay_inc = i_state.delay_count + 1'b1;

        // advance timing
        if (i_state.cur_op == i2cmbe_pkg::OP_NONE) begin
            if (i_opcode == i2cmbe_pkg::OP_START || i_opcode == i2cmbe_pkg::OP_STOP ||
                i_opcode == i2cmbe_pkg::OP_SEND  || i_opcode == i2cmbe_pkg::OP_READ ||
                i_opcode == i2cmbe_pkg::OP_WAIT) begin
                n.cur_op      = i_opcode;
                n.phase       = i2cmbe_pkg::PH_ENTRY;
                n.delay_count = '0;
                n.poll_count  = '0;
                n.bit_count   = '0;
                if (i_opcode == i2cmbe_pkg::OP_SEND) begin
                    n.shift_reg = i_tx_byte;
                end
                if (i_opcode == i2cmbe_pkg::OP_READ) begin
                    n.shift_reg  = '0;
                    n.ack_choice = i_send_ack;
                end
                enter = 1'b1;
            end
        end else if (i_state.cur_op == i2cmbe_pkg::OP_WAIT &&
                     i_state.phase == i2cmbe_pkg::PH_WAIT_POLL) begin
            if (!i_sda_sample) begin
                n.scl = 1'b0;
                done  = 1'b1;
            end else if (i_state.poll_count >= i_poll_limit) begin
                n.phase       = i2cmbe_pkg::PH_WAIT_STOP;
                n.delay_count = '0;
                enter         = 1'b1;
            end else begin
                n.poll_count = i_state.poll_count + 1'b1;
            end
        end else if (delay_inc >= i_delay_ticks) begin
            n.delay_count = '0;
            n.phase       = i_state.phase + 1'b1;
            enter         = 1'b1;
        end else begin
            n.delay_count = delay_inc;
        end

        // actions on entering a phase
        if (enter) begin
            unique case (n.cur_op)
                i2cmbe_pkg::OP_START: begin
                    if (n.phase == i2cmbe_pkg::PH_ENTRY) begin
                        n.sda_oe = 1'b1;
                        n.sda    = 1'b1;
                        n.scl    = 1'b1;
                    end else if (n.phase == i2cmbe_pkg::PH_START_SDA) begin
                        n.sda = 1'b0;
                    end else if (n.phase >= i2cmbe_pkg::PH_START_END) begin
                        n.scl = 1'b0;
                        done  = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_STOP: begin
                    if (n.phase == i2cmbe_pkg::PH_ENTRY) begin
                        n.sda_oe = 1'b1;
                        n.scl    = 1'b0;
                        n.sda    = 1'b0;
                    end else if (n.phase == i2cmbe_pkg::PH_STOP_RISE) begin
                        n.scl = 1'b1;
                        n.sda = 1'b1;
                    end else if (n.phase >= i2cmbe_pkg::PH_STOP_END) begin
                        done = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_SEND: begin
                    if (n.phase == i2cmbe_pkg::PH_ENTRY) begin
                        n.sda_oe    = 1'b1;
                        n.scl       = 1'b0;
                        n.sda       = n.shift_reg[i2cmbe_pkg::BYTE_W-1];
                        n.shift_reg = {n.shift_reg[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
                    end else if (n.phase == i2cmbe_pkg::PH_SEND_HIGH) begin
                        n.scl = 1'b1;
                    end else if (n.phase == i2cmbe_pkg::PH_SEND_LOW) begin
                        n.scl = 1'b0;
                    end else if (n.phase >= i2cmbe_pkg::PH_SEND_NEXT) begin
                        if (n.bit_count >= i2cmbe_pkg::LAST_BIT) begin
                            done = 1'b1;
                        end else begin
                            n.bit_count = n.bit_count + 1'b1;
                            n.phase     = i2cmbe_pkg::PH_ENTRY;
                            n.scl       = 1'b0;
                            n.sda       = n.shift_reg[i2cmbe_pkg::BYTE_W-1];
                            n.shift_reg = {n.shift_reg[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
                        end
                    end
                end
                i2cmbe_pkg::OP_READ: begin
                    if (n.phase == i2cmbe_pkg::PH_ENTRY) begin
                        n.sda_oe = 1'b0;
                        n.scl    = 1'b0;
                    end else if (n.phase == i2cmbe_pkg::PH_READ_HIGH) begin
                        n.scl       = 1'b1;
                        n.shift_reg = {n.shift_reg[i2cmbe_pkg::BYTE_W-2:0], i_sda_sample};
                    end else if (n.phase == i2cmbe_pkg::PH_READ_NEXT) begin
                        n.scl = 1'b0;
                        if (n.bit_count < i2cmbe_pkg::LAST_BIT) begin
                            n.bit_count = n.bit_count + 1'b1;
                            n.phase     = i2cmbe_pkg::PH_ENTRY;
                        end else begin
                            // acknowledge slot: ack drives low, nack high
                            n.sda_oe = 1'b1;
                            n.sda    = ~n.ack_choice;
                        end
                    end else if (n.phase == i2cmbe_pkg::PH_RACK_HIGH) begin
                        n.scl = 1'b1;
                    end else if (n.phase >= i2cmbe_pkg::PH_RACK_END) begin
                        n.scl     = 1'b0;
                        n.rx_hold = n.shift_reg;
                        done      = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_WAIT: begin
                    if (n.phase == i2cmbe_pkg::PH_ENTRY) begin
                        n.sda_oe = 1'b0;
                        n.sda    = 1'b1;
                    end else if (n.phase == i2cmbe_pkg::PH_WAIT_HIGH) begin
                        n.scl = 1'b1;
                    end else if (n.phase == i2cmbe_pkg::PH_WAIT_STOP) begin
                        n.sda_oe = 1'b1;
                        n.scl    = 1'b0;
                        n.sda    = 1'b0;
                    end else if (n.phase == i2cmbe_pkg::PH_WAIT_RISE) begin
                        n.scl = 1'b1;
                        n.sda = 1'b1;
                    end else if (n.phase >= i2cmbe_pkg::PH_WAIT_END) begin
                        done = 1'b1;
                        fail = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        if (done) begin
            n.cur_op      = i2cmbe_pkg::OP_NONE;
            n.phase       = i2cmbe_pkg::PH_ENTRY;
            n.delay_count = '0;
        end
    end

    assign o_state      = n;
    assign o_flags.done = done;
    assign o_flags.fail = fail;

endmodule

>>> test/tb_i2c_master_bit_engine_core.sv
// testbench for the i2c master bit engine: tick stimulus checked against a line predictor
module tb_i2c_master_bit_engine_core;
    import i2cmbe_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int IDLE_PCT       = 11;
    localparam int BUSY_NOISE_PCT = 20;
    localparam int NEVER_LOW      = 1 << 30;
    localparam int SDA_RANDOM     = -1;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {ENTRY_BUSY, ENTRY_DONE, ENTRY_FAILED} t_entry_status;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              sda_oe;
        logic              idle;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              failed;
    } t_line_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cmbe_req_if req_ch ();
    i2cmbe_res_if res_ch ();
    i2cmbe_cfg_if cfg_ch ();

    i2c_master_bit_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // predicted engine state
    logic [OPCODE_W-1:0] m_op      = OP_NONE;
    logic [PHASE_W-1:0]  m_phase   = PH_ENTRY;
    logic [3:0]          m_bits    = 4'd0;
    logic [BYTE_W-1:0]   m_shift   = 8'd0;
    logic [TICKS_W-1:0]  m_dcnt    = 10'd0;
    logic [TICKS_W-1:0]  m_pcnt    = 10'd0;
    logic                m_scl     = 1'b1;
    logic                m_sda     = 1'b1;
    logic                m_oe      = 1'b1;
    logic                m_ack_sel = 1'b0;
    logic [BYTE_W-1:0]   m_rx      = 8'd0;

    logic [TICKS_W-1:0] cfg_unit_ticks = DELAY_UNIT_TICKS_RST;
    logic [TICKS_W-1:0] cfg_poll_limit = ACK_POLL_LIMIT_RST;

    t_line_result expected_lines[$];
    int ticks_sent      = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int gap_pct         = IDLE_PCT;
    int stall_pct       = IDLE_PCT;

    function automatic void shift_out_bit();
        m_scl   = 1'b0;
        m_sda   = m_shift[7];
        m_shift = {m_shift[6:0], 1'b0};
    endfunction

    function automatic t_entry_status enter_phase(input logic sda_in);
        case (m_op)
            OP_START: begin
                if (m_phase == PH_ENTRY) begin
                    m_oe = 1'b1; m_sda = 1'b1; m_scl = 1'b1;
                end else if (m_phase == PH_START_SDA) begin
                    m_sda = 1'b0;
                end else if (m_phase >= PH_START_END) begin
                    m_scl = 1'b0;
                    return ENTRY_DONE;
                end
            end
            OP_STOP: begin
                if (m_phase == PH_ENTRY) begin
                    m_oe = 1'b1; m_scl = 1'b0; m_sda = 1'b0;
                end else if (m_phase == PH_STOP_RISE) begin
                    m_scl = 1'b1; m_sda = 1'b1;
                end else if (m_phase >= PH_STOP_END) begin
                    return ENTRY_DONE;
                end
            end
            OP_SEND: begin
                if (m_phase == PH_ENTRY) begin
                    m_oe = 1'b1;
                    shift_out_bit();
                end else if (m_phase == PH_SEND_HIGH) begin
                    m_scl = 1'b1;
                end else if (m_phase == PH_SEND_LOW) begin
                    m_scl = 1'b0;
                end else if (m_phase >= PH_SEND_NEXT) begin
                    if (m_bits >= LAST_BIT) return ENTRY_DONE;
                    m_bits  = m_bits + 4'd1;
                    m_phase = PH_ENTRY;
                    shift_out_bit();
                end
            end
            OP_READ: begin
                if (m_phase == PH_ENTRY) begin
                    m_oe = 1'b0; m_scl = 1'b0;
                end else if (m_phase == PH_READ_HIGH) begin
                    m_scl   = 1'b1;
                    m_shift = {m_shift[6:0], sda_in};
                end else if (m_phase == PH_READ_NEXT) begin
                    m_scl = 1'b0;
                    if (m_bits < LAST_BIT) begin
                        m_bits  = m_bits + 4'd1;
                        m_phase = PH_ENTRY;
                    end else begin
                        m_oe  = 1'b1;
                        m_sda = ~m_ack_sel;
                    end
                end else if (m_phase == PH_RACK_HIGH) begin
                    m_scl = 1'b1;
                end else if (m_phase >= PH_RACK_END) begin
                    m_scl = 1'b0;
                    m_rx  = m_shift;
                    return ENTRY_DONE;
                end
            end
            OP_WAIT: begin
                if (m_phase == PH_ENTRY) begin
                    m_oe = 1'b0; m_sda = 1'b1;
                end else if (m_phase == PH_WAIT_HIGH) begin
                    m_scl = 1'b1;
                end else if (m_phase == PH_WAIT_STOP) begin
                    m_oe = 1'b1; m_scl = 1'b0; m_sda = 1'b0;
                end else if (m_phase == PH_WAIT_RISE) begin
                    m_scl = 1'b1; m_sda = 1'b1;
                end else if (m_phase >= PH_WAIT_END) begin
                    return ENTRY_FAILED;
                end
            end
            default: return ENTRY_DONE;
        endcase
        return ENTRY_BUSY;
    endfunction

    function automatic t_line_result predict_line_state(input logic [OPCODE_W-1:0] opc,
                                                        input logic [BYTE_W-1:0] txb,
                                                        input logic sack, input logic sda_in);
        t_entry_status st;
        t_line_result  r;
        st = ENTRY_BUSY;
        if (m_op == OP_NONE) begin
            if (opc >= OP_START && opc <= OP_WAIT) begin
                m_op    = opc;
                m_phase = PH_ENTRY;
                m_dcnt  = 10'd0;
                m_pcnt  = 10'd0;
                m_bits  = 4'd0;
                if (opc == OP_SEND) m_shift = txb;
                if (opc == OP_READ) begin
                    m_shift   = 8'd0;
                    m_ack_sel = sack;
                end
                st = enter_phase(sda_in);
            end
        end else if (m_op == OP_WAIT && m_phase == PH_WAIT_POLL) begin
            if (sda_in == 1'b0) begin
                m_scl = 1'b0;
                st    = ENTRY_DONE;
            end else if ({1'b0, m_pcnt} + 11'd1 > {1'b0, cfg_poll_limit}) begin
                m_phase = PH_WAIT_STOP;
                m_dcnt  = 10'd0;
                st      = enter_phase(sda_in);
            end else begin
                m_pcnt = m_pcnt + 10'd1;
            end
        end else begin
            m_dcnt = m_dcnt + 10'd1;
            if (m_dcnt >= cfg_unit_ticks) begin
                m_dcnt  = 10'd0;
                m_phase = m_phase + 4'd1;
                st      = enter_phase(sda_in);
            end
        end
        if (st != ENTRY_BUSY) begin
            m_op    = OP_NONE;
            m_phase = PH_ENTRY;
            m_dcnt  = 10'd0;
        end
        r.scl    = m_scl;
        r.sda    = m_sda;
        r.sda_oe = m_oe;
        r.idle   = (m_op == OP_NONE);
        r.done   = (st != ENTRY_BUSY);
        r.rx     = m_rx;
        r.failed = (st == ENTRY_FAILED);
        return r;
    endfunction

    task automatic send_tick(input logic [OPCODE_W-1:0] opc, input logic [BYTE_W-1:0] txb,
                             input logic sack, input logic sda_in);
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= opc;
        req_ch.tx_byte    <= txb;
        req_ch.send_ack   <= sack;
        req_ch.sda_sample <= sda_in;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        expected_lines.push_back(predict_line_state(opc, txb, sack, sda_in));
        ticks_sent++;
    endtask

    // issues one command and keeps ticking until the engine is idle again
    task automatic run_command(input logic [OPCODE_W-1:0] opc, input logic [BYTE_W-1:0] txb,
                               input logic sack, input int sda_low_from, input int noise_pct);
        int   n;
        logic sda;
        n = 0;
        do begin
            sda = (sda_low_from < 0) ? 1'($urandom_range(1)) : (n < sda_low_from);
            send_tick(opc, txb, sack, sda);
            n++;
            opc  = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : OP_NONE;
            txb  = 8'($urandom);
            sack = 1'($urandom_range(1));
        end while (m_op != OP_NONE);
    endtask

    function automatic int pick_ack_from();
        case ($urandom_range(9))
            0, 1:    return NEVER_LOW;
            2, 3:    return SDA_RANDOM;
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    task automatic run_transaction();
        logic [BYTE_W-1:0] addr;
        int                n_data;
        addr   = 8'($urandom);
        n_data = $urandom_range(1, 3);
        run_command(OP_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, BUSY_NOISE_PCT);
        run_command(OP_SEND, addr, 1'($urandom_range(1)), SDA_RANDOM, BUSY_NOISE_PCT);
        run_command(OP_WAIT, 8'($urandom), 1'($urandom_range(1)), pick_ack_from(),
                    BUSY_NOISE_PCT);
        repeat (n_data) begin
            if (addr[0]) begin
                run_command(OP_READ, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM,
                            BUSY_NOISE_PCT);
            end else begin
                run_command(OP_SEND, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM,
                            BUSY_NOISE_PCT);
                run_command(OP_WAIT, 8'($urandom), 1'($urandom_range(1)), pick_ack_from(),
                            BUSY_NOISE_PCT);
            end
        end
        run_command(OP_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, BUSY_NOISE_PCT);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [TICKS_W-1:0] unit, input logic [TICKS_W-1:0] limit);
        drain_results();
        for (int i = 0; i < 2; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= (i == 0) ? REG_DELAY_UNIT_TICKS : REG_ACK_POLL_LIMIT;
            cfg_ch.data  <= (i == 0) ? unit : limit;
            @(posedge i_clk);
            while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
            if (i == 0) cfg_unit_ticks = unit;
            else cfg_poll_limit = limit;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        repeat (3) run_command(OP_NONE, 8'h00, 1'b0, NEVER_LOW, 0);
    endtask

    task automatic test_directed_commands();
        run_command(OP_START, 8'h00, 1'b0, NEVER_LOW, 0);
        run_command(OP_SEND, 8'h00, 1'b0, NEVER_LOW, 0);
        run_command(OP_WAIT, 8'h00, 1'b0, 0, 0);
        run_command(OP_SEND, 8'hFF, 1'b1, 0, 0);
        // no ack: times out and issues a stop
        run_command(OP_WAIT, 8'hFF, 1'b1, NEVER_LOW, 0);
        run_command(OP_START, 8'hFF, 1'b1, SDA_RANDOM, 0);
        // commands arriving while busy must be ignored
        run_command(OP_SEND, 8'hA5, 1'b0, SDA_RANDOM, 100);
        run_command(OP_WAIT, 8'h5A, 1'b0, 20, 0);
        run_command(OP_READ, 8'hFF, 1'b1, 0, 0);
        run_command(OP_READ, 8'h00, 1'b0, NEVER_LOW, 0);
        run_command(OP_READ, 8'h3C, 1'b1, SDA_RANDOM, 100);
        run_command(OP_STOP, 8'hFF, 1'b1, SDA_RANDOM, 0);
        run_command(OP_SPARE_LO, 8'hFF, 1'b1, 0, 0);
        run_command(OP_SPARE_HI, 8'h00, 1'b0, NEVER_LOW, 0);
        run_command(OP_NONE, 8'hFF, 1'b1, 0, 0);
    endtask

    task automatic test_zero_settings();
        configure(10'd0, 10'd0);
        run_command(OP_START, 8'h81, 1'b0, SDA_RANDOM, 0);
        run_command(OP_SEND, 8'($urandom), 1'b0, SDA_RANDOM, 0);
        run_command(OP_WAIT, 8'h00, 1'b0, NEVER_LOW, 0);
        run_command(OP_WAIT, 8'h00, 1'b0, 0, 0);
        run_command(OP_READ, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
    endtask

    task automatic test_long_unit();
        configure(10'd6, 10'd1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, BUSY_NOISE_PCT);
        run_command(OP_WAIT, 8'h00, 1'b0, NEVER_LOW, BUSY_NOISE_PCT);
    endtask

    task automatic test_longest_poll();
        configure(10'd1, 10'd1023);
        run_command(OP_WAIT, 8'hFF, 1'b0, 40, BUSY_NOISE_PCT);
    endtask

    task automatic test_random_traffic(input logic [TICKS_W-1:0] unit,
                                       input logic [TICKS_W-1:0] limit,
                                       input int tick_budget, input bit no_idling);
        int first_tick;
        configure(unit, limit);
        if (no_idling) begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < tick_budget) begin
            if ($urandom_range(99) < 15) begin
                run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                            SDA_RANDOM, BUSY_NOISE_PCT);
            end else begin
                run_transaction();
            end
        end
        gap_pct   = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_NONE;
        req_ch.tx_byte    <= 8'h00;
        req_ch.send_ack   <= 1'b0;
        req_ch.sda_sample <= 1'b1;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_DELAY_UNIT_TICKS;
        cfg_ch.data       <= DELAY_UNIT_TICKS_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_commands();
        test_zero_settings();
        test_random_traffic(10'd2, 10'd2, 60, 1'b0);
        test_long_unit();
        test_longest_poll();
        test_random_traffic(10'd1, 10'd6, 100, 1'b1);

        drain_results();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : line_check
        t_line_result got;
        t_line_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.scl    = res_ch.scl_level;
            got.sda    = res_ch.sda_level;
            got.sda_oe = res_ch.sda_drive_enable;
            got.idle   = res_ch.ready_res;
            got.done   = res_ch.op_done;
            got.rx     = res_ch.rx_byte;
            got.failed = res_ch.ack_failed;
            if (expected_lines.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_lines.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected scl=%b sda=%b oe=%b idle=%b done=%b",
                                  " rx=%h fail=%b, got scl=%b sda=%b oe=%b idle=%b done=%b",
                                  " rx=%h fail=%b"}, results_seen,
                                 want.scl, want.sda, want.sda_oe, want.idle, want.done,
                                 want.rx, want.failed, got.scl, got.sda, got.sda_oe,
                                 got.idle, got.done, got.rx, got.failed);
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
